// ===== hdl/wmb_pkg.sv =====
// wmb_pkg: shared types and constants of the world matrix builder.
// Payload structs, control struct of the multiply-accumulate unit, CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wmb_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CORDIC_MAX  = 24;

   typedef struct packed {
      logic                          kind;
      logic [3:0]                    element_index;
      logic signed [VALUE_WIDTH-1:0] element_value;
      logic signed [VALUE_WIDTH-1:0] scale_x;
      logic signed [VALUE_WIDTH-1:0] scale_y;
      logic signed [VALUE_WIDTH-1:0] scale_z;
      logic [15:0]                   angle_x;
      logic [15:0]                   angle_y;
      logic [15:0]                   angle_z;
      logic signed [VALUE_WIDTH-1:0] move_x;
      logic signed [VALUE_WIDTH-1:0] move_y;
      logic signed [VALUE_WIDTH-1:0] move_z;
   } req_type;

   typedef struct packed {
      logic [3:0]                    out_index;
      logic signed [VALUE_WIDTH-1:0] out_value;
      logic                          out_last;
   } rsp_type;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctrl_type;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN32 [CORDIC_MAX] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

endpackage
`default_nettype wire

// ===== hdl/srt_world_matrix_builder.sv =====
// srt_world_matrix_builder: sequencer, matrix registers and parent store.
// Instantiates wmb_cordic and wmb_mac; uses wmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Builds the row-vector world matrix W = S*Rz*Rx*Ry*T and multiplies it by a
// stored parent matrix (identity after reset). A load transfer (kind 0) writes
// one parent element and gives no result. A compute transfer (kind 1) gives 16
// result transfers, row-major, out_last on the last. A compute item takes three
// CORDIC runs (one sine/cosine unit, one micro-rotation per cycle), then five
// 4x4 matrix products on one multiply-accumulate unit, each element in four
// products, drain and round, then the 16 result transfers, which rsp_stall
// can hold. req_stall is high from the compute transfer until the last result
// transfer. Values are signed Q(32-FRAC_BITS).FRAC_BITS, rounded half up and
// saturated after every product.
module srt_world_matrix_builder
   import wmb_pkg::*;
#(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int VW = VALUE_WIDTH;
   localparam logic signed [VW-1:0] ONE  = VW'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [VW-1:0] VMAX = VW'((64'sd1 <<< (VW - 1)) - 1);
   localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

   // product sequence
   localparam logic [2:0] MM_RXRY   = 3'd0;
   localparam logic [2:0] MM_RZ     = 3'd1;
   localparam logic [2:0] MM_TRN    = 3'd2;
   localparam logic [2:0] MM_SCL    = 3'd3;
   localparam logic [2:0] MM_PARENT = 3'd4;

   localparam logic [2:0] PH_ROUND = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CORDIC = 4'b0010,
      ST_MUL    = 4'b0100,
      ST_OUT    = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic signed [VW-1:0] parent_ff [16];
   logic signed [VW-1:0] w_ff [16];
   logic signed [VW-1:0] t_ff [16];

   logic signed [VW-1:0] scx_ff, scy_ff, scz_ff, mvx_ff, mvy_ff, mvz_ff;
   logic [15:0]          ang_y_ff, ang_z_ff;
   logic signed [VW-1:0] sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff;

   logic [1:0] axis_ff, axis_in;
   logic [2:0] mm_ff, mm_in;
   logic [3:0] e_ff, e_in;
   logic [2:0] ph_ff, ph_in;
   logic [3:0] oidx_ff, oidx_in;

   logic                 req_xfer, rsp_xfer;
   logic                 cor_start, cor_done;
   logic [15:0]          cor_angle;
   logic signed [VW-1:0] cor_sin, cor_cos;
   mac_ctrl_type         mac_ctrl;
   logic signed [VW-1:0] op_a, op_b, mac_res;
   logic [3:0]           ia, ib, w_addr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   function automatic logic signed [VW-1:0] neg_sat(input logic signed [VW-1:0] v);
      return (v == VMIN) ? VMAX : -v;
   endfunction

   function automatic logic signed [VW-1:0] rot_x(input logic [3:0] idx,
         input logic signed [VW-1:0] s, input logic signed [VW-1:0] c);
      unique case (idx)
         4'd0, 4'd15: return ONE;
         4'd5, 4'd10: return c;
         4'd6:        return s;
         4'd9:        return neg_sat(s);
         default:     return '0;
      endcase
   endfunction

   function automatic logic signed [VW-1:0] rot_y(input logic [3:0] idx,
         input logic signed [VW-1:0] s, input logic signed [VW-1:0] c);
      unique case (idx)
         4'd5, 4'd15: return ONE;
         4'd0, 4'd10: return c;
         4'd8:        return s;
         4'd2:        return neg_sat(s);
         default:     return '0;
      endcase
   endfunction

   function automatic logic signed [VW-1:0] rot_z(input logic [3:0] idx,
         input logic signed [VW-1:0] s, input logic signed [VW-1:0] c);
      unique case (idx)
         4'd10, 4'd15: return ONE;
         4'd0, 4'd5:   return c;
         4'd1:         return s;
         4'd4:         return neg_sat(s);
         default:      return '0;
      endcase
   endfunction

   // diagonal d0..d2 with one at 15, offsets o0..o2 in the bottom row
   function automatic logic signed [VW-1:0] affine(input logic [3:0] idx,
         input logic signed [VW-1:0] d0, input logic signed [VW-1:0] d1,
         input logic signed [VW-1:0] d2, input logic signed [VW-1:0] o0,
         input logic signed [VW-1:0] o1, input logic signed [VW-1:0] o2);
      unique case (idx)
         4'd0:    return d0;
         4'd5:    return d1;
         4'd10:   return d2;
         4'd15:   return ONE;
         4'd12:   return o0;
         4'd13:   return o1;
         4'd14:   return o2;
         default: return '0;
      endcase
   endfunction

   // operand fetch: element e = {row, col}, term k = ph[1:0]
   always_comb begin
      ia     = {e_ff[3:2], ph_ff[1:0]};
      ib     = {ph_ff[1:0], e_ff[1:0]};
      w_addr = (mm_ff == MM_TRN || mm_ff == MM_PARENT) ? ia : ib;
      unique case (mm_ff)
         MM_RXRY: begin
            op_a = rot_x(ia, sx_ff, cx_ff);
            op_b = rot_y(ib, sy_ff, cy_ff);
         end
         MM_RZ: begin
            op_a = rot_z(ia, sz_ff, cz_ff);
            op_b = w_ff[w_addr];
         end
         MM_TRN: begin
            op_a = w_ff[w_addr];
            op_b = affine(ib, ONE, ONE, ONE, mvx_ff, mvy_ff, mvz_ff);
         end
         MM_SCL: begin
            op_a = affine(ia, scx_ff, scy_ff, scz_ff, '0, '0, '0);
            op_b = w_ff[w_addr];
         end
         default: begin
            op_a = w_ff[w_addr];
            op_b = parent_ff[ib];
         end
      endcase
   end

   // MAC phases: multiply on 0..3, accumulate on 1..4, round on 5
   always_comb begin
      mac_ctrl.mul_en   = (state_ff == ST_MUL) && (ph_ff < 3'd4);
      mac_ctrl.acc_load = (state_ff == ST_MUL) && (ph_ff == 3'd1);
      mac_ctrl.acc_add  = (state_ff == ST_MUL) && (ph_ff >= 3'd2) && (ph_ff <= 3'd4);
   end

   always_comb begin
      cor_start = 1'b0;
      cor_angle = req_data.angle_x;
      state_in  = state_ff;
      axis_in   = axis_ff;
      mm_in     = mm_ff;
      e_in      = e_ff;
      ph_in     = ph_ff;
      oidx_in   = oidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_data.kind == KIND_COMPUTE) begin
               cor_start = 1'b1;
               axis_in   = 2'd0;
               state_in  = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            cor_angle = (axis_ff == 2'd0) ? ang_y_ff : ang_z_ff;
            if (cor_done) begin
               if (axis_ff == 2'd2) begin
                  state_in = ST_MUL;
                  mm_in    = MM_RXRY;
                  e_in     = '0;
                  ph_in    = '0;
               end else begin
                  cor_start = 1'b1;
                  axis_in   = axis_ff + 2'd1;
               end
            end
         end
         ST_MUL: begin
            ph_in = ph_ff + 3'd1;
            if (ph_ff == PH_ROUND) begin
               ph_in = '0;
               e_in  = e_ff + 4'd1;
               if (e_ff == 4'd15) begin
                  mm_in = mm_ff + 3'd1;
                  if (mm_ff == MM_PARENT) begin
                     state_in = ST_OUT;
                     oidx_in  = '0;
                  end
               end
            end
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               oidx_in = oidx_ff + 4'd1;
               if (oidx_ff == 4'd15) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 16; i++) begin
            parent_ff[i] <= (i % 5 == 0) ? ONE : '0;
         end
      end else begin
         state_ff <= state_in;
         if (req_xfer && req_data.kind == KIND_LOAD) begin
            parent_ff[req_data.element_index] <= req_data.element_value;
         end
      end
      axis_ff <= axis_in;
      mm_ff   <= mm_in;
      e_ff    <= e_in;
      ph_ff   <= ph_in;
      oidx_ff <= oidx_in;
      if (req_xfer) begin
         scx_ff   <= req_data.scale_x;
         scy_ff   <= req_data.scale_y;
         scz_ff   <= req_data.scale_z;
         mvx_ff   <= req_data.move_x;
         mvy_ff   <= req_data.move_y;
         mvz_ff   <= req_data.move_z;
         ang_y_ff <= req_data.angle_y;
         ang_z_ff <= req_data.angle_z;
      end
      if (cor_done) begin
         unique case (axis_ff)
            2'd0: begin sx_ff <= cor_sin; cx_ff <= cor_cos; end
            2'd1: begin sy_ff <= cor_sin; cy_ff <= cor_cos; end
            default: begin sz_ff <= cor_sin; cz_ff <= cor_cos; end
         endcase
      end
      if (state_ff == ST_MUL && ph_ff == PH_ROUND) begin
         t_ff[e_ff] <= mac_res;
      end
      // working matrix takes the finished product together with its last element,
      // so the first term of the next product already sees it
      if (state_ff == ST_MUL && ph_ff == PH_ROUND && e_ff == 4'd15) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= t_ff[i];
         end
         w_ff[15] <= mac_res;
      end
   end

   wmb_cordic #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   wmb_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mac_res)
   );

   assign rsp_data.out_index = oidx_ff;
   assign rsp_data.out_value = t_ff[oidx_ff];
   assign rsp_data.out_last  = (oidx_ff == 4'd15);

   // the block is busy whenever results are pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result pending while input side open");

   // last transfer returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_data.out_last) |=> (!rsp_valid && !req_stall))
      else $error("block not idle after last result");

   // sine/cosine unit reports only during the angle phase
   a_cordic_phase: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_CORDIC))
      else $error("CORDIC done outside angle phase");

endmodule
`default_nettype wire

// ===== hdl/wmb_cordic.sv =====
// wmb_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Gives sine and cosine of a 16-bit binary angle; uses wmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wmb_cordic
   import wmb_pkg::*;
#(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [15:0]                   angle,
   output logic                               done,
   output logic signed [VALUE_WIDTH-1:0]      sin_out,
   output logic signed [VALUE_WIDTH-1:0]      cos_out
);

   localparam int CW    = 34;
   localparam int STEPS = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;
   localparam logic [4:0] LAST = 5'(STEPS - 1);
   localparam logic signed [CW-1:0] X_INIT = 34'sd652032874;
   localparam logic signed [CW-1:0] HALF   = CW'(64'sd1 <<< (29 - FRAC_BITS));
   localparam logic signed [CW-1:0] VMAX   = CW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
   localparam logic signed [CW-1:0] VMIN   = -VMAX - 1;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]           q_ff, q_in;
   logic [4:0]           i_ff, i_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   logic [16:0]          a_plus;
   logic [1:0]           q_new;
   logic [15:0]          r_new;
   logic signed [CW-1:0] dx, dy, atan_v, c_raw, s_raw;

   always_comb begin
      a_plus = {1'b0, angle} + 17'd8192;
      q_new  = a_plus[15:14];
      r_new  = angle - {q_new, 14'd0};
      dx     = y_ff >>> i_ff;
      dy     = x_ff >>> i_ff;
      atan_v = CW'(ATAN_TURN32[i_ff]);
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      q_in    = q_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = X_INIT;
         y_in    = '0;
         z_in    = CW'($signed({r_new, 16'd0}));
         q_in    = q_new;
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      q_ff <= q_in;
      i_ff <= i_in;
   end

   // quadrant restore
   always_comb begin
      unique case (q_ff)
         2'd0: begin c_raw = x_ff;  s_raw = y_ff;  end
         2'd1: begin c_raw = -y_ff; s_raw = x_ff;  end
         2'd2: begin c_raw = -x_ff; s_raw = -y_ff; end
         default: begin c_raw = y_ff; s_raw = -x_ff; end
      endcase
   end

   function automatic logic signed [VALUE_WIDTH-1:0] to_frac(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] t;
      t = (v + HALF) >>> (30 - FRAC_BITS);
      if (t > VMAX) return VMAX[VALUE_WIDTH-1:0];
      if (t < VMIN) return VMIN[VALUE_WIDTH-1:0];
      return t[VALUE_WIDTH-1:0];
   endfunction

   assign sin_out = to_frac(s_raw);
   assign cos_out = to_frac(c_raw);
   assign done    = done_ff;

endmodule
`default_nettype wire

// ===== hdl/wmb_mac.sv =====
// wmb_mac: registered multiplier and wide accumulator with round half up and saturation.
// Uses wmb_pkg for mac_ctrl_type and VALUE_WIDTH.
`timescale 1ns / 1ps
`default_nettype none
module wmb_mac
   import wmb_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire mac_ctrl_type                  ctrl,
   input  wire logic signed [VALUE_WIDTH-1:0] op_a,
   input  wire logic signed [VALUE_WIDTH-1:0] op_b,
   output logic signed [VALUE_WIDTH-1:0]      result
);

   localparam int PW = 2 * VALUE_WIDTH;
   localparam int AW = PW + 2;
   localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [AW-1:0] VMAX = (AW'(1) <<< (VALUE_WIDTH - 1)) - AW'(1);
   localparam logic signed [AW-1:0] VMIN = -VMAX - AW'(1);

   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] rnd;

   always_comb begin
      prod_in = ctrl.mul_en ? op_a * op_b : prod_ff;
      acc_in  = acc_ff;
      if (ctrl.acc_load) begin
         acc_in = AW'(prod_ff);
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
      rnd = (acc_ff + HALF) >>> FRAC_BITS;
      if (rnd > VMAX) begin
         result = VMAX[VALUE_WIDTH-1:0];
      end else if (rnd < VMIN) begin
         result = VMIN[VALUE_WIDTH-1:0];
      end else begin
         result = rnd[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule
`default_nettype wire

// ===== verif/tb_srt_world_matrix_builder.sv =====
// tb_srt_world_matrix_builder: self-checking testbench of the world matrix builder.
// Drives parent loads and compute transfers, predicts all 16 elements, checks them.
// Depends on wmb_pkg and srt_world_matrix_builder.
`timescale 1ns / 1ps
`default_nettype none
module tb_srt_world_matrix_builder;
   import wmb_pkg::*;

   typedef longint mat_t [16];

   // Predicts the world matrix elements and checks what comes out of the block.
   class matrix_scoreboard;
      mat_t    parent;
      rsp_type expected_q[$];
      int      errors;

      function new();
         errors = 0;
         make_identity(parent);
      endfunction

      static function void make_identity(output mat_t m);
         for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 64'sd65536 : 64'sd0;
      endfunction

      static function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // exact four-term sum, round half up at bit 16, saturate
      static function void mat_mul(input mat_t a, input mat_t b, output mat_t o);
         logic signed [127:0] acc, ta, tb;
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               acc = '0;
               for (int k = 0; k < 4; k++) begin
                  ta = a[r*4+k];
                  tb = b[k*4+c];
                  acc = acc + ta * tb;
               end
               acc = (acc + 128'sd32768) >>> 16;
               if (acc > 128'sd2147483647) o[r*4+c] = 64'sd2147483647;
               else if (acc < -128'sd2147483648) o[r*4+c] = -64'sd2147483648;
               else o[r*4+c] = longint'(acc);
            end
         end
      endfunction

      static function longint q30_to_q16(longint v);
         return sat32((v + 64'sd8192) >>> 14);
      endfunction

      // fold by quarter turns, then 16 micro-rotations in Q30
      static function void sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
         longint q, r, x, y, z, dx, dy, c, s;
         q = ((longint'(ang) + 8192) >> 14) & 3;
         r = (longint'(ang) - q * 16384) & 64'hFFFF;
         if (r >= 32768) r = r - 65536;
         z = r * 65536;
         x = 652032874;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - longint'(ATAN_TURN32[i]);
            end else begin
               x = x + dx; y = y - dy; z = z + longint'(ATAN_TURN32[i]);
            end
         end
         case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
         sn = q30_to_q16(s);
         cs = q30_to_q16(c);
      endfunction

      function void note_input(req_type r);
         mat_t rx, ry, rz, tm, sm, w;
         longint s, c;
         rsp_type e;
         if (r.kind == KIND_LOAD) begin
            parent[r.element_index] = longint'(r.element_value);
            return;
         end
         make_identity(sm);
         sm[0] = longint'(r.scale_x);
         sm[5] = longint'(r.scale_y);
         sm[10] = longint'(r.scale_z);
         make_identity(rx);
         sin_cos(r.angle_x, s, c);
         rx[5] = c; rx[6] = s; rx[9] = sat32(-s); rx[10] = c;
         make_identity(ry);
         sin_cos(r.angle_y, s, c);
         ry[0] = c; ry[2] = sat32(-s); ry[8] = s; ry[10] = c;
         make_identity(rz);
         sin_cos(r.angle_z, s, c);
         rz[0] = c; rz[1] = s; rz[4] = sat32(-s); rz[5] = c;
         make_identity(tm);
         tm[12] = longint'(r.move_x);
         tm[13] = longint'(r.move_y);
         tm[14] = longint'(r.move_z);
         mat_mul(rx, ry, w);
         mat_mul(rz, w, w);
         mat_mul(w, tm, w);
         mat_mul(sm, w, w);
         mat_mul(w, parent, w);
         for (int i = 0; i < 16; i++) begin
            e.out_index = i[3:0];
            e.out_value = w[i][31:0];
            e.out_last  = (i == 15);
            expected_q.push_back(e);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result index %0d value %h", $time,
                     got.out_index, got.out_value);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.out_index !== e.out_index) begin
            $display("%0t: out_index expected %0d actual %0d", $time, e.out_index,
                     got.out_index);
            errors++;
         end
         if (got.out_value !== e.out_value) begin
            $display("%0t: out_value[%0d] expected %h actual %h", $time, e.out_index,
                     e.out_value, got.out_value);
            errors++;
         end
         if (got.out_last !== e.out_last) begin
            $display("%0t: out_last[%0d] expected %b actual %b", $time, e.out_index,
                     e.out_last, got.out_last);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // when set, neither side inserts gaps any more
   bit      quiet = 1'b0;

   // cycles left in the current result stall burst
   int      stall_left = 0;

   matrix_scoreboard board = new();

   srt_world_matrix_builder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Generous bound on the whole run, result stalls included.
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // Result side: random stall bursts, checked on every accepted transfer.
   always @(negedge clock) begin
      if (quiet || reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Mostly moderate Q16.16 values, sometimes full 32-bit range.
   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
   endfunction

   function automatic req_type random_req(logic kind);
      req_type r;
      r.kind          = kind;
      r.element_index = $urandom_range(0, 15);
      r.element_value = ($urandom_range(0, 3) == 0) ? $urandom : pick_value();
      r.scale_x       = pick_value();
      r.scale_y       = pick_value();
      r.scale_z       = pick_value();
      r.angle_x       = $urandom;
      r.angle_y       = $urandom;
      r.angle_z       = $urandom;
      r.move_x        = pick_value();
      r.move_y        = pick_value();
      r.move_z        = pick_value();
      return r;
   endfunction

   function automatic req_type compute_req(logic [31:0] sc, logic [15:0] ang, logic [31:0] mv);
      req_type r;
      r = random_req(KIND_COMPUTE);
      r.scale_x = sc; r.scale_y = sc; r.scale_z = sc;
      r.angle_x = ang; r.angle_y = ang; r.angle_z = ang;
      r.move_x = mv; r.move_y = mv; r.move_z = mv;
      return r;
   endfunction

   function automatic req_type load_req(int idx, logic [31:0] v);
      req_type r;
      r = random_req(KIND_LOAD);
      r.element_index = idx[3:0];
      r.element_value = v;
      return r;
   endfunction

   // One transfer on the request side; valid stays high into the next item
   // unless a gap is drawn.
   task automatic send_item(req_type r);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      board.note_input(r);
   endtask

   initial begin
      req_type r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identity parent, zero angles, then the fold boundaries.
      send_item(compute_req(32'h0001_0000, 16'h0000, 32'h0000_0000));
      send_item(compute_req(32'h0001_0000, 16'h1FFF, 32'h0003_8000));
      send_item(compute_req(32'h0002_0000, 16'h2000, 32'hFFFF_0000));
      send_item(compute_req(32'h0001_0000, 16'h4000, 32'h0000_0001));
      send_item(compute_req(32'h0001_0000, 16'h6000, 32'h0001_0000));
      send_item(compute_req(32'hFFFF_0000, 16'h8000, 32'h0000_0000));
      send_item(compute_req(32'h0001_0000, 16'hC000, 32'h0010_0000));
      send_item(compute_req(32'h0001_0000, 16'hFFFF, 32'h0000_0000));
      // saturation at both ends of scale and translation
      send_item(compute_req(32'h7FFF_FFFF, 16'h1234, 32'h7FFF_FFFF));
      send_item(compute_req(32'h8000_0000, 16'h9ABC, 32'h8000_0000));
      // parent with extreme entries, then a compute through it
      send_item(load_req(0, 32'h7FFF_FFFF));
      send_item(load_req(5, 32'h8000_0000));
      send_item(load_req(10, 32'h0002_0000));
      send_item(load_req(12, 32'hFFFF_FFFF));
      send_item(load_req(15, 32'h0000_0000));
      send_item(compute_req(32'h0001_0000, 16'h0800, 32'h0100_0000));
      // back to the identity parent
      for (int i = 0; i < 16; i++)
         if (i == 0 || i == 5 || i == 10 || i == 12 || i == 15)
            send_item(load_req(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0));
      send_item(compute_req(32'h0000_8000, 16'hE000, 32'h0000_0000));

      // Random: bursts of parent loads followed by computes.
      for (int n = 0; n < 60; n++) begin
         if (n >= 50) quiet = 1'b1;
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) send_item(random_req(KIND_LOAD));
         end
         send_item(random_req(KIND_COMPUTE));
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
